// ----- hdl/median_filter_3x3_core_defines.svh -----
// Assertion macros shared by the median filter modules.
`ifndef MEDIAN_FILTER_3X3_CORE_DEFINES_SVH
`define MEDIAN_FILTER_3X3_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MF3_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("median filter check failed");
`define MF3_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("median filter check failed");
`else
`define MF3_ASSERT(label, expr)
`define MF3_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ----- hdl/mf3_pkg.sv -----
// Types, constants and compare functions of the 3x3 median filter.
`timescale 1ns / 1ps
package mf3_pkg;

   localparam int CHAN_W        = 8;
   localparam int NUM_CHAN      = 3;
   localparam int PIXEL_W       = CHAN_W * NUM_CHAN;
   localparam int WIN_N         = 3;
   localparam int WIDTH_REG_W   = 12;
   localparam int HEIGHT_REG_W  = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int DEF_MAX_WIDTH = 2048;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pix_type;
   typedef logic [WIN_N-1:0][CHAN_W-1:0] trio_type;

   typedef enum logic {
      OP_PIXEL,
      OP_FLUSH
   } op_type;

   typedef enum logic [2:0] {
      SRC_MEDIAN,
      SRC_CENTER,
      SRC_OLD_LAST,
      SRC_LINE_A,
      SRC_LINE_B
   } src_type;

   typedef struct packed {
      op_type  op;
      src_type src;
      logic    emit;
      logic    last_col;
      logic    frame_end;
      pix_type pix;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);

   function automatic chan_type min2(input chan_type a, input chan_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic chan_type max2(input chan_type a, input chan_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic chan_type min3(input chan_type a, input chan_type b, input chan_type c);
      return min2(min2(a, b), c);
   endfunction

   function automatic chan_type max3(input chan_type a, input chan_type b, input chan_type c);
      return max2(max2(a, b), c);
   endfunction

   function automatic chan_type med3(input chan_type a, input chan_type b, input chan_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // Index 0 holds the smallest value, index 2 the largest.
   function automatic trio_type sort3(input chan_type a, input chan_type b, input chan_type c);
      chan_type lo1;
      chan_type hi1;
      chan_type lo2;
      trio_type res;
      lo1    = min2(a, b);
      hi1    = max2(a, b);
      lo2    = min2(hi1, c);
      res[2] = max2(hi1, c);
      res[0] = min2(lo1, lo2);
      res[1] = max2(lo1, lo2);
      return res;
   endfunction

endpackage

// ----- hdl/mf3_ram.sv -----
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps
module mf3_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/mf3_queue.sv -----
// Short command queue between the classifier and the filter datapath.
`timescale 1ns / 1ps
module mf3_queue #(
   parameter int DATA_W = 40,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              push_fire;
   logic              pop_fire;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + CW'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/mf3_front.sv -----
// Input classifier: frame position counters, configuration and command generation.
`timescale 1ns / 1ps
`include "median_filter_3x3_core_defines.svh"
module mf3_front
   import mf3_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   localparam int COL_W = $clog2(MAX_WIDTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIXEL_W-1:0]    req_tdata,
   input  logic                  req_tuser,
   input  logic                  q_ready,
   output logic                  push_valid,
   output cmd_type               push_cmd,
   output logic [COL_W-1:0]      push_col
);

   localparam int CW1 = $clog2(MAX_WIDTH + 1);
   localparam int EW  = (CW1 > WIDTH_REG_W) ? CW1 : WIDTH_REG_W;

   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]        in_col_ff, in_col_in;
   logic [COL_W-1:0]        out_col_ff, out_col_in;
   logic [HEIGHT_REG_W-1:0] in_row_ff, in_row_in;
   logic [HEIGHT_REG_W-1:0] out_row_ff, out_row_in;
   logic [EW-1:0]           width_ext;
   logic [CW1-1:0]          eff_w;
   logic [COL_W-1:0]        wm1;
   logic [HEIGHT_REG_W-1:0] hm1;
   logic                    accept;
   logic                    in_done;
   logic                    emit_now;
   logic                    frame_last;
   logic                    interior;
   cmd_type                 cmd;

   assign req_tready = q_ready;
   assign accept     = req_tvalid && q_ready;

   // A width of zero acts as one; widths above the line memory are clamped.
   always_comb begin
      width_ext = EW'(width_ff);
      if (width_ext == '0) begin
         eff_w = CW1'(1);
      end else if (width_ext > EW'(MAX_WIDTH)) begin
         eff_w = CW1'(MAX_WIDTH);
      end else begin
         eff_w = CW1'(width_ext);
      end
      wm1 = COL_W'(eff_w - CW1'(1));
      hm1 = (height_ff == '0) ? '0 : height_ff - HEIGHT_REG_W'(1);
   end

   assign in_done    = (in_row_ff > hm1);
   assign frame_last = (out_row_ff == hm1) && (out_col_ff == wm1);
   assign interior   = (out_row_ff != '0) && (out_row_ff < hm1) &&
                       (out_col_ff != '0) && (out_col_ff < wm1);

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      cmd           = '0;
      cmd.op        = OP_PIXEL;
      cmd.src       = SRC_CENTER;
      cmd.pix       = req_tdata;
      push_col      = in_col_ff;
      push_valid    = 1'b0;
      emit_now      = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = csr_data[WIDTH_REG_W-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_data[HEIGHT_REG_W-1:0];
            end
            default: begin
            end
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (accept) begin
         if (in_done) begin
            // The frame is in; every further word flushes one stored pixel.
            push_valid = 1'b1;
            cmd.op     = OP_FLUSH;
            cmd.src    = (out_row_ff == hm1) ? SRC_LINE_A : SRC_LINE_B;
            push_col   = out_col_ff;
            emit_now   = 1'b1;
         end else if (req_tuser == REQ_PIXEL) begin
            push_valid   = 1'b1;
            cmd.op       = OP_PIXEL;
            cmd.last_col = (in_col_ff == wm1);
            push_col     = in_col_ff;
            if (in_col_ff == wm1) begin
               in_col_in = '0;
               in_row_in = in_row_ff + HEIGHT_REG_W'(1);
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
            emit_now = (in_row_ff >= HEIGHT_REG_W'(2)) ||
                       ((in_row_ff == HEIGHT_REG_W'(1)) && (in_col_ff != '0));
            if (in_col_ff == '0) begin
               cmd.src = SRC_OLD_LAST;
            end else if (interior) begin
               cmd.src = SRC_MEDIAN;
            end else begin
               cmd.src = SRC_CENTER;
            end
         end
      end
      cmd.emit      = emit_now;
      cmd.frame_end = frame_last;
      if (emit_now) begin
         if (frame_last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (out_col_ff == wm1) begin
            out_col_in = '0;
            out_row_in = out_row_ff + HEIGHT_REG_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end
   end

   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   `MF3_ASSERT(a_in_col_in_row, in_col_ff <= wm1)
   `MF3_ASSERT(a_out_col_in_row, out_col_ff <= wm1)

endmodule

// ----- hdl/mf3_back.sv -----
// Filter datapath: line memory, window, median network and output register.
`timescale 1ns / 1ps
`include "median_filter_3x3_core_defines.svh"
module mf3_back
   import mf3_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   localparam int COL_W = $clog2(MAX_WIDTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  cmd_type            pop_cmd,
   input  logic [COL_W-1:0]   pop_col,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [PIXEL_W-1:0] rsp_tdata,
   output logic               rsp_tlast
);

   localparam int LINE_W = 2 * PIXEL_W;

   logic                advance;
   logic                ram_we;
   logic                ram_re;
   logic [LINE_W-1:0]   ram_wdata;
   logic [LINE_W-1:0]   ram_rdata;
   logic [LINE_W-1:0]   line;
   pix_type             line_a;
   pix_type             line_b;

   logic                s1_valid_ff;
   cmd_type             s1_cmd_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic                fwd_hit_ff;
   logic [LINE_W-1:0]   fwd_data_ff;

   pix_type             win_ff [2][WIN_N];
   pix_type             win9 [WIN_N][WIN_N];
   pix_type             last1_ff;
   pix_type             last2_ff;
   pix_type             pass_in;

   trio_type            s2_sorted_in [NUM_CHAN][WIN_N];
   trio_type            s2_sorted_ff [NUM_CHAN][WIN_N];
   logic                s2_valid_ff;
   logic                s2_med_ff;
   logic                s2_end_ff;
   pix_type             s2_pass_ff;

   chan_type            s3_lo_in [NUM_CHAN];
   chan_type            s3_mid_in [NUM_CHAN];
   chan_type            s3_hi_in [NUM_CHAN];
   chan_type            s3_lo_ff [NUM_CHAN];
   chan_type            s3_mid_ff [NUM_CHAN];
   chan_type            s3_hi_ff [NUM_CHAN];
   logic                s3_valid_ff;
   logic                s3_med_ff;
   logic                s3_end_ff;
   pix_type             s3_pass_ff;

   pix_type             med_in;
   logic                rsp_valid_ff;
   pix_type             rsp_data_ff;
   logic                rsp_last_ff;

   assign advance   = !rsp_valid_ff || rsp_tready;
   assign pop_ready = advance;
   assign ram_re    = advance && pop_valid;

   // Each line entry holds the previous row in the low half and the row before it above.
   mf3_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_col_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (pop_col),
      .rd_data (ram_rdata)
   );

   assign line      = fwd_hit_ff ? fwd_data_ff : ram_rdata;
   assign line_a    = line[PIXEL_W-1:0];
   assign line_b    = line[LINE_W-1:PIXEL_W];
   assign ram_we    = advance && s1_valid_ff && (s1_cmd_ff.op == OP_PIXEL);
   assign ram_wdata = {line_a, s1_cmd_ff.pix};

   always_comb begin
      for (int r = 0; r < WIN_N; r++) begin
         win9[0][r] = win_ff[0][r];
         win9[1][r] = win_ff[1][r];
      end
      win9[2][0] = line_b;
      win9[2][1] = line_a;
      win9[2][2] = s1_cmd_ff.pix;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         for (int c = 0; c < WIN_N; c++) begin
            s2_sorted_in[ch][c] = sort3(win9[c][0][ch], win9[c][1][ch], win9[c][2][ch]);
         end
      end
   end

   always_comb begin
      case (s1_cmd_ff.src)
         SRC_MEDIAN:   pass_in = '0;
         SRC_CENTER:   pass_in = win_ff[1][1];
         SRC_OLD_LAST: pass_in = last2_ff;
         SRC_LINE_A:   pass_in = line_a;
         SRC_LINE_B:   pass_in = line_b;
         default:      pass_in = win_ff[1][1];
      endcase
   end

   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         s3_lo_in[ch]  = max3(s2_sorted_ff[ch][0][0], s2_sorted_ff[ch][1][0],
                              s2_sorted_ff[ch][2][0]);
         s3_mid_in[ch] = med3(s2_sorted_ff[ch][0][1], s2_sorted_ff[ch][1][1],
                              s2_sorted_ff[ch][2][1]);
         s3_hi_in[ch]  = min3(s2_sorted_ff[ch][0][2], s2_sorted_ff[ch][1][2],
                              s2_sorted_ff[ch][2][2]);
         med_in[ch]    = med3(s3_lo_ff[ch], s3_mid_ff[ch], s3_hi_ff[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= pop_valid;
         fwd_hit_ff   <= ram_we && pop_valid && (s1_col_ff == pop_col);
         s2_valid_ff  <= s1_valid_ff && s1_cmd_ff.emit;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff    <= pop_cmd;
         s1_col_ff    <= pop_col;
         fwd_data_ff  <= ram_wdata;
         s2_sorted_ff <= s2_sorted_in;
         s2_med_ff    <= (s1_cmd_ff.src == SRC_MEDIAN);
         s2_end_ff    <= s1_cmd_ff.frame_end;
         s2_pass_ff   <= pass_in;
         s3_lo_ff     <= s3_lo_in;
         s3_mid_ff    <= s3_mid_in;
         s3_hi_ff     <= s3_hi_in;
         s3_med_ff    <= s2_med_ff;
         s3_end_ff    <= s2_end_ff;
         s3_pass_ff   <= s2_pass_ff;
         rsp_data_ff  <= s3_med_ff ? med_in : s3_pass_ff;
         rsp_last_ff  <= s3_end_ff;
      end
      if (ram_we) begin
         for (int r = 0; r < WIN_N; r++) begin
            win_ff[0][r] <= win9[1][r];
            win_ff[1][r] <= win9[2][r];
         end
         if (s1_cmd_ff.last_col) begin
            last1_ff <= s1_cmd_ff.pix;
            last2_ff <= last1_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `MF3_ASSERT_NEXT(a_fwd_on_collision, ram_we && ram_re && (s1_col_ff == pop_col), fwd_hit_ff)
   `MF3_ASSERT(a_fwd_has_item, !fwd_hit_ff || s1_valid_ff)
   `MF3_ASSERT_NEXT(a_stage3_holds, s3_valid_ff && !advance, s3_valid_ff)

endmodule

// ----- hdl/median_filter_3x3_core.sv -----
// A result passes registers s1, s2, s3 and the output register after its window's last word.
// Results lag the pixel stream by one image row plus one pixel; drain words flush the tail.
// Throughput: one word per clock unless stalled, set by one line read and write per pixel.
// Reset: synchronous; clears counters, queue and valid flags and loads 640 x 480.
// The line memory and window are not cleared; no result depends on their old contents.
`timescale 1ns / 1ps
module median_filter_3x3_core
   import mf3_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIXEL_W-1:0]    req_tdata,   // in_chan0, in_chan1, in_chan2
   input  logic                  req_tuser,   // operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIXEL_W-1:0]    rsp_tdata,   // out_chan0, out_chan1, out_chan2
   output logic                  rsp_tlast
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int QW    = CMD_W + COL_W;

   logic             q_ready;
   logic             push_valid;
   cmd_type          push_cmd;
   logic [COL_W-1:0] push_col;
   logic [QW-1:0]    push_data;
   logic             pop_valid;
   logic             pop_ready;
   logic [QW-1:0]    pop_data;
   cmd_type          pop_cmd;
   logic [COL_W-1:0] pop_col;

   mf3_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_col   (push_col)
   );

   assign push_data = {push_col, push_cmd};

   mf3_queue #(
      .DATA_W (QW),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (q_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_cmd = cmd_type'(pop_data[CMD_W-1:0]);
   assign pop_col = pop_data[QW-1:CMD_W];

   mf3_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .pop_col    (pop_col),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
